FILE: src/lfochr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfochr_pkg
// Shared types, constants and the LFO table builder for the chorus block.
// ----------------------------------------------------------------------------
package lfochr_pkg;

    localparam int MAX_DELAY_DEF   = 1024;
    localparam int SAMPLE_W_DEF    = 16;
    localparam int SINE_DEPTH_DEF  = 256;

    localparam int PHASE_W       = 32;
    localparam int PHASE_STEP_W  = 31;
    localparam int DEPTH_W       = 10;
    localparam int MIX_W         = 17;
    localparam int LFO_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [MIX_W-1:0]        MIX_ONE          = 17'd65536;
    localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 31'd58435;
    localparam logic [DEPTH_W-1:0]      DEPTH_RESET      = 10'd18;
    localparam logic [MIX_W-1:0]        MIX_RESET        = 17'd22938;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX        = 2'd2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic load;
        logic advance;
    } t_lfo_ctl;

    // LFO value (sin + 1) / 2 in Q1.16 for table entry k of a 2^aw entry table.
    function automatic logic [LFO_W-1:0] lfo_entry(input int unsigned k,
                                                   input int unsigned aw);
        logic [63:0]        f;
        logic [63:0]        r;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        pos;
        logic [63:0]        neg;
        logic [1:0]         q;
        logic signed [63:0] s;
        logic signed [63:0] v;
        f = 64'(k) << (32 - aw);
        q = f[31:30];
        r = f & (Q30_ONE - 64'd1);
        if (q[0]) begin
            r = Q30_ONE - r;
        end
        t    = (r * HALF_PI_Q30) >> 30;
        t2   = (t * t) >> 30;
        term = t;
        pos  = t;
        neg  = 64'd0;
        for (int n = 1; n <= 12; n++) begin
            term = (term * t2) >> 30;
            case (n)
                1: begin
                    term = term / 64'd6;
                end
                2: begin
                    term = term / 64'd20;
                end
                3: begin
                    term = term / 64'd42;
                end
                4: begin
                    term = term / 64'd72;
                end
                5: begin
                    term = term / 64'd110;
                end
                6: begin
                    term = term / 64'd156;
                end
                7: begin
                    term = term / 64'd210;
                end
                8: begin
                    term = term / 64'd272;
                end
                9: begin
                    term = term / 64'd342;
                end
                10: begin
                    term = term / 64'd420;
                end
                11: begin
                    term = term / 64'd506;
                end
                default: begin
                    term = term / 64'd600;
                end
            endcase
            if ((n & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = $signed(pos) - $signed(neg);
        if (q[1]) begin
            s = -s;
        end
        v = $signed(Q30_ONE) + s + 64'sd16384;
        if (v < 0) begin
            v = 64'sd0;
        end
        v = v >>> 15;
        if (v > 64'sd65536) begin
            v = 64'sd65536;
        end
        return v[LFO_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/lfochr_lfo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfochr_lfo
// Phase accumulator and registered sine table lookup for the chorus LFO.
// ----------------------------------------------------------------------------
module lfochr_lfo
    import lfochr_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_lfo_ctl                i_ctl,
    input  wire logic [PHASE_STEP_W-1:0] i_phase_step,
    output logic      [LFO_W-1:0]        o_lfo
);

    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);

    logic [LFO_W-1:0]   w_tab [SINE_TABLE_DEPTH];
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [LFO_W-1:0]   r_lfo;

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [LFO_W-1:0] TabEntry = lfo_entry(g, SINE_AW);
        assign w_tab[g] = TabEntry;
    end

    assign n_phase = r_phase + PHASE_W'(i_phase_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.advance) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_lfo <= w_tab[r_phase[PHASE_W-1 -: SINE_AW]];
        end
    end

    assign o_lfo = r_lfo;

endmodule
`default_nettype wire

FILE: src/lfo_modulated_chorus.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfo_modulated_chorus
// Mono chorus: a sine LFO modulates the tap of a circular delay store.
// ----------------------------------------------------------------------------
// Each sample passes four steps: LFO table read, delay calculation with the
// delay store read and write-back, the dry/wet multiply, then rounding and
// saturation into the output register. The four-step sequencer around the
// single-port-pair delay store takes one sample at a time. A finished word
// waits in the output register, so a new sample is accepted while it is held.
// The store needs no clearing pass after reset: a fill flag marks entries not
// yet written, and those read as zero. Configuration words may be written
// at any time the block is idle.
module lfo_modulated_chorus
    import lfochr_pkg::*;
#(
    parameter int MAX_DELAY        = MAX_DELAY_DEF,
    parameter int SAMPLE_WIDTH     = SAMPLE_W_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                 i_cfg_data,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // Bits from the lowest up: in_sample, then zero fill.
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // Bits from the lowest up: out_sample, then zero fill.
    output logic      [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] o_m_axis_tdata
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int AW      = $clog2(MAX_DELAY);
    localparam int DLY_W   = (AW > 11) ? AW : 11;
    localparam int PROD_W  = SAMPLE_WIDTH + 18;
    localparam int ACC_W   = SAMPLE_WIDTH + 19;

    localparam logic [DLY_W-1:0] DLY_MAX  = DLY_W'(MAX_DELAY - 1);
    localparam logic [AW:0]      STORE_SZ = (AW + 1)'(MAX_DELAY);
    localparam logic [AW-1:0]    WP_LAST  = AW'(MAX_DELAY - 1);
    localparam logic signed [ACC_W:0] RES_MAX = (ACC_W + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W:0] RES_MIN = ~RES_MAX;
    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(32768);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DELAY = 4'b0010,
        ST_MIX   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [PHASE_STEP_W-1:0]   r_phase_step;
    logic [DEPTH_W-1:0]        r_depth;
    logic [MIX_W-1:0]          r_mix;
    logic [AW-1:0]             r_wp;
    logic                      r_full;
    logic signed [SAMPLE_WIDTH-1:0] r_dry;
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic                      r_unwritten;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_valid;
    logic [SAMPLE_WIDTH-1:0]   r_out_data;
    logic [SAMPLE_WIDTH-1:0]   r_store [MAX_DELAY];

    t_lfo_ctl                  w_lfo_ctl;
    logic [LFO_W-1:0]          w_lfo;
    logic                      w_in_take;
    logic                      w_out_load;
    logic [LFO_W+DEPTH_W-1:0]  w_dly_prod;
    logic [DLY_W-1:0]          w_dly_raw;
    logic [DLY_W-1:0]          w_dly_clip;
    logic [AW-1:0]             w_dly;
    logic [AW:0]               w_rd_sum;
    logic [AW-1:0]             w_rd_addr;
    logic [MIX_W-1:0]          w_mix_sat;
    logic [MIX_W-1:0]          w_mix_inv;
    logic signed [SAMPLE_WIDTH-1:0] w_wet;
    logic signed [PROD_W-1:0]  w_dry_term;
    logic signed [PROD_W-1:0]  w_wet_term;
    logic signed [ACC_W:0]     w_rounded;
    logic [SAMPLE_WIDTH-1:0]   w_res;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);

    assign w_lfo_ctl.load    = w_in_take;
    assign w_lfo_ctl.advance = (r_state == ST_DELAY);

    lfochr_lfo #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_lfo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_lfo_ctl),
        .i_phase_step(r_phase_step),
        .o_lfo       (w_lfo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RESET;
            r_depth      <= DEPTH_RESET;
            r_mix        <= MIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data[PHASE_STEP_W-1:0];
                end
                CFG_DEPTH: begin
                    r_depth <= i_cfg_data[DEPTH_W-1:0];
                end
                CFG_MIX: begin
                    r_mix <= i_cfg_data[MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_dly_prod = LFO_W'(w_lfo) * (LFO_W + DEPTH_W)'(r_depth);
    assign w_dly_raw  = DLY_W'(w_dly_prod[LFO_W+DEPTH_W-1:16]);

    always_comb begin
        w_dly_clip = w_dly_raw;
        if (w_dly_clip == '0) begin
            w_dly_clip = DLY_W'(1);
        end
        if (w_dly_clip > DLY_MAX) begin
            w_dly_clip = DLY_MAX;
        end
    end

    assign w_dly    = w_dly_clip[AW-1:0];
    assign w_rd_sum = {1'b0, r_wp} + STORE_SZ - {1'b0, w_dly};
    assign w_rd_addr = (w_rd_sum >= STORE_SZ) ? AW'(w_rd_sum - STORE_SZ) : w_rd_sum[AW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_state = ST_DELAY;
                end
            end
            ST_DELAY: begin
                n_state = ST_MIX;
            end
            ST_MIX: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DELAY) begin
                if (r_wp == WP_LAST) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + AW'(1);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DELAY) begin
            r_store[r_wp] <= r_dry;
            r_rdata       <= r_store[w_rd_addr];
        end
    end

    assign w_mix_sat  = (r_mix > MIX_ONE) ? MIX_ONE : r_mix;
    assign w_mix_inv  = MIX_ONE - w_mix_sat;
    assign w_wet      = r_unwritten ? '0 : r_rdata;
    assign w_dry_term = r_dry * $signed({1'b0, w_mix_inv});
    assign w_wet_term = w_wet * $signed({1'b0, w_mix_sat});

    assign w_rounded = ((ACC_W + 1)'(r_acc) + RND_HALF) >>> 16;

    always_comb begin
        if (w_rounded > RES_MAX) begin
            w_res = RES_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_rounded < RES_MIN) begin
            w_res = RES_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            w_res = w_rounded[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_dry <= $signed(i_s_axis_tdata[SAMPLE_WIDTH-1:0]);
        end
        if (r_state == ST_DELAY) begin
            r_unwritten <= !r_full && ({1'b0, r_wp} < {1'b0, w_dly});
        end
        if (r_state == ST_MIX) begin
            r_acc <= ACC_W'(w_dry_term) + ACC_W'(w_wet_term);
        end
        if (w_out_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_data);

    a_accept_starts_delay : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == ST_DELAY))
        else $error("accepted sample did not enter the delay step");

    a_wp_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_wp} < STORE_SZ)
        else $error("write pointer beyond the delay store");

    a_tap_not_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELAY) |-> (w_rd_addr != r_wp))
        else $error("delay tap reads the entry being written");

    a_out_from_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("output word appeared outside the output step");

endmodule
`default_nettype wire
